/* rtl/assert_macros.svh */
// Assertion macros used by the checker module of the sprite blitter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define SSB_ASSERT_CLK(lbl, clk_sig, rst_n_sig, prop) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error("%m: assertion failed");

// Concurrent assertion on the block clock and reset (clk, arst_n).
`define SSB_ASSERT(lbl, prop) \
	`SSB_ASSERT_CLK(lbl, clk, arst_n, prop)

`endif

/* rtl/ssb_pkg.sv */
// Shared types, constants and the reciprocal step table of the sprite blitter.
package ssb_pkg;

	// Default geometry
	localparam int SCREEN_WIDTH_DEF  = 144;
	localparam int SPRITE_TEXELS_DEF = 256;

	// Field widths
	localparam int SIZE_W      = 5;
	localparam int COORD_FRAC  = 11;
	localparam int COORD_W     = 16 - COORD_FRAC;
	localparam int TADDR_W     = 2 * SIZE_W + 1;
	localparam int FADDR_W     = 15;
	localparam int CFG_DATA_W  = 8;
	localparam int CFG_INDEX_W = 3;

	// Step numerator: 1.0 in 1.15 texel units per 4.4 scale unit
	localparam logic [15:0] STEP_NUM = 16'h8000;

	// Command codes
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_CLIP_LEFT     = 3'd0,
		CFG_CLIP_RIGHT    = 3'd1,
		CFG_CLIP_TOP      = 3'd2,
		CFG_CLIP_BOTTOM   = 3'd3,
		CFG_SPRITE_WIDTH  = 3'd4,
		CFG_SPRITE_HEIGHT = 3'd5
	} cfg_index_t;

	// Configuration reset values
	localparam logic [7:0]        CLIP_LEFT_RST     = 8'd0;
	localparam logic [7:0]        CLIP_RIGHT_RST    = 8'd144;
	localparam logic [7:0]        CLIP_TOP_RST      = 8'd16;
	localparam logic [7:0]        CLIP_BOTTOM_RST   = 8'd167;
	localparam logic [SIZE_W-1:0] SPRITE_WIDTH_RST  = 5'd16;
	localparam logic [SIZE_W-1:0] SPRITE_HEIGHT_RST = 5'd14;

	typedef struct packed {
		logic [7:0]        clip_left;
		logic [7:0]        clip_right;
		logic [7:0]        clip_top;
		logic [7:0]        clip_bottom;
		logic [SIZE_W-1:0] sprite_width;
		logic [SIZE_W-1:0] sprite_height;
	} cfg_t;

	// Input transaction
	typedef struct packed {
		logic               cmd;
		logic [7:0]         texel_index;
		logic [7:0]         texel_value;
		logic [7:0]         screen_x;
		logic [7:0]         screen_y;
		logic signed [15:0] sprite_x;
		logic signed [15:0] sprite_y;
		logic [7:0]         scale_x;
		logic [7:0]         scale_y;
		logic [7:0]         tint;
	} in_item_t;

	// Result transaction
	typedef struct packed {
		logic               write_enable;
		logic [7:0]         pixel_value;
		logic [FADDR_W-1:0] frame_address;
	} out_item_t;

	// Per-axis unit operands
	typedef struct packed {
		logic [7:0]         pos;
		logic signed [15:0] origin;
		logic [7:0]         scale;
		logic [SIZE_W-1:0]  size;
		logic [7:0]         clo;
		logic [7:0]         chi;
	} axis_in_t;

	// Per-axis stage load enables
	typedef struct packed {
		logic s1;
		logic s2;
	} axis_en_t;

	// Per-axis result: inside the clipped extent, and texel coordinate
	typedef struct packed {
		logic               hit;
		logic [COORD_W-1:0] coord;
	} axis_out_t;

	// Step per screen pixel, indexed by the 4.4 scale; zero scale never draws
	typedef logic [15:0] step_lut_t [256];

	// Restoring long division, evaluated once at elaboration
	function automatic step_lut_t build_step_lut();
		step_lut_t   lut;
		logic [16:0] rem;
		logic [15:0] quo;
		lut[0] = '0;
		for (int i = 1; i < 256; i++) begin
			rem = '0;
			quo = '0;
			for (int b = 15; b >= 0; b--) begin
				rem = {rem[15:0], STEP_NUM[b]};
				if (rem >= 17'(i)) begin
					rem = rem - 17'(i);
					quo[b] = 1'b1;
				end
			end
			lut[i] = quo;
		end
		return lut;
	endfunction

	localparam step_lut_t STEP_LUT = build_step_lut();

endpackage

/* rtl/ssb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ssb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/ssb_cfg.sv */
// Configuration register file of the sprite blitter: clip window and sprite size.
module ssb_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           we,
	input  logic [ssb_pkg::CFG_INDEX_W-1:0] index,
	input  logic [ssb_pkg::CFG_DATA_W-1:0]  data,
	output ssb_pkg::cfg_t                  cfg
);
	import ssb_pkg::*;

	cfg_t cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clip_left     <= CLIP_LEFT_RST;
			cfg_q.clip_right    <= CLIP_RIGHT_RST;
			cfg_q.clip_top      <= CLIP_TOP_RST;
			cfg_q.clip_bottom   <= CLIP_BOTTOM_RST;
			cfg_q.sprite_width  <= SPRITE_WIDTH_RST;
			cfg_q.sprite_height <= SPRITE_HEIGHT_RST;
		end else if (we) begin
			case (index)
				CFG_CLIP_LEFT:     cfg_q.clip_left     <= data[7:0];
				CFG_CLIP_RIGHT:    cfg_q.clip_right    <= data[7:0];
				CFG_CLIP_TOP:      cfg_q.clip_top      <= data[7:0];
				CFG_CLIP_BOTTOM:   cfg_q.clip_bottom   <= data[7:0];
				CFG_SPRITE_WIDTH:  cfg_q.sprite_width  <= data[SIZE_W-1:0];
				CFG_SPRITE_HEIGHT: cfg_q.sprite_height <= data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/ssb_axis.sv */
// Two-stage per-axis unit: clipped extent test and scaled texel coordinate.
module ssb_axis (
	input  logic                clk,
	input  ssb_pkg::axis_en_t   en,
	input  ssb_pkg::axis_in_t   ain,
	output ssb_pkg::axis_out_t  res
);
	import ssb_pkg::*;

	logic [2*8-4:0]     ext_prod;
	logic [7:0]         ext;
	logic signed [17:0] offs;
	logic               clip_ok;

	logic [7:0]         ext_s1;
	logic signed [17:0] offs_s1;
	logic [15:0]        step_s1;
	logic               clip_s1;

	logic [23:0]        coord_prod;
	logic               in_extent;

	logic               hit_s2;
	logic [COORD_W-1:0] coord_s2;

	// Stage 1 operands: extent, offset from the sprite edge, clip window, step
	always_comb begin
		ext_prod = 13'(ain.size) * 13'(ain.scale);
		ext      = ext_prod[11:4];
		offs     = $signed({10'd0, ain.pos}) - $signed({{2{ain.origin[15]}}, ain.origin});
		clip_ok  = (ain.pos >= ain.clo) && (ain.pos < ain.chi);
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			ext_s1  <= ext;
			offs_s1 <= offs;
			step_s1 <= STEP_LUT[ain.scale];
			clip_s1 <= clip_ok;
		end
	end

	// Stage 2: extent test and 16-bit wrapping coordinate, integer part kept.
	// Inside the extent the offset is below 255, so its low byte is exact.
	always_comb begin
		coord_prod = 24'(offs_s1[7:0]) * 24'(step_s1);
		in_extent  = clip_s1 && !offs_s1[17] && (offs_s1[16:0] < 17'(ext_s1));
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			hit_s2   <= in_extent;
			coord_s2 <= coord_prod[COORD_FRAC +: COORD_W];
		end
	end

	assign res.hit   = hit_s2;
	assign res.coord = coord_s2;

endmodule

/* rtl/scaled_sprite_blitter_core.sv */
// Top level of the scaled, clipped, tinted sprite blitter, one screen pixel per transaction.
// Throughput: one transaction per cycle while rsp_stall is low, loads and queries alike.
// Pipeline: five register stages, the two per-axis stages,
//   texel address, sprite store read and the output register.
// Reset: arst_n clears the stage valid bits and loads the configuration defaults;
//   sprite store contents are undefined until loaded, no clearing pass.
module scaled_sprite_blitter_core #(
	parameter int SCREEN_WIDTH  = ssb_pkg::SCREEN_WIDTH_DEF,
	parameter int SPRITE_TEXELS = ssb_pkg::SPRITE_TEXELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  ssb_pkg::in_item_t               req,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output ssb_pkg::out_item_t              rsp,
	input  logic                            cfg_we,
	input  logic [ssb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ssb_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import ssb_pkg::*;

	localparam int AW   = $clog2(SPRITE_TEXELS);
	localparam int FA_W = 8 + $clog2(SCREEN_WIDTH) + 1;

	cfg_t      cfg;
	axis_in_t  ax_x_in, ax_y_in;
	axis_out_t ax_x, ax_y;
	axis_en_t  ax_en;

	// Stage valid bits and advance conditions
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	// Payload carried down the pipe
	logic               cmd_s1, cmd_s2, cmd_s3, cmd_s4;
	logic [7:0]         tint_s1, tint_s2, tint_s3, tint_s4;
	logic [FADDR_W-1:0] fa_s1, fa_s2, fa_s3, fa_s4;
	logic [7:0]         idx_s1, idx_s2, idx_s3;
	logic [7:0]         val_s1, val_s2, val_s3;
	logic               hit_s3, hit_s4;
	logic [TADDR_W-1:0] ta_s3;
	out_item_t          rsp_s5;

	logic [FA_W-1:0]    fa_full;
	logic [TADDR_W-1:0] ta_next;
	logic               ta_ok;
	logic               store_we;
	logic [7:0]         texel;
	logic               draw;
	out_item_t          rsp_next;

	ssb_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// Backpressure: a stage loads when it is empty or its successor loads
	assign rdy_s5    = !v_s5 || !rsp_stall;
	assign rdy_s4    = !v_s4 || rdy_s5;
	assign rdy_s3    = !v_s3 || rdy_s4;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign req_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= req_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	// Per-axis units, stages 1 and 2
	assign ax_en.s1 = rdy_s1;
	assign ax_en.s2 = rdy_s2;

	always_comb begin
		ax_x_in.pos    = req.screen_x;
		ax_x_in.origin = req.sprite_x;
		ax_x_in.scale  = req.scale_x;
		ax_x_in.size   = cfg.sprite_width;
		ax_x_in.clo    = cfg.clip_left;
		ax_x_in.chi    = cfg.clip_right;
		ax_y_in.pos    = req.screen_y;
		ax_y_in.origin = req.sprite_y;
		ax_y_in.scale  = req.scale_y;
		ax_y_in.size   = cfg.sprite_height;
		ax_y_in.clo    = cfg.clip_top;
		ax_y_in.chi    = cfg.clip_bottom;
	end

	ssb_axis u_axis_x (
		.clk (clk),
		.en  (ax_en),
		.ain (ax_x_in),
		.res (ax_x)
	);

	ssb_axis u_axis_y (
		.clk (clk),
		.en  (ax_en),
		.ain (ax_y_in),
		.res (ax_y)
	);

	// Stage 1: frame buffer address, masked to the address width
	assign fa_full = FA_W'(req.screen_y) * FA_W'(SCREEN_WIDTH) + FA_W'(req.screen_x);

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			cmd_s1  <= req.cmd;
			tint_s1 <= req.tint;
			fa_s1   <= FADDR_W'(fa_full);
			idx_s1  <= req.texel_index;
			val_s1  <= req.texel_value;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			cmd_s2  <= cmd_s1;
			tint_s2 <= tint_s1;
			fa_s2   <= fa_s1;
			idx_s2  <= idx_s1;
			val_s2  <= val_s1;
		end
	end

	// Stage 3: texel address row * width + column
	assign ta_next = TADDR_W'(ax_y.coord) * TADDR_W'(cfg.sprite_width) + TADDR_W'(ax_x.coord);

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			cmd_s3  <= cmd_s2;
			tint_s3 <= tint_s2;
			fa_s3   <= fa_s2;
			idx_s3  <= idx_s2;
			val_s3  <= val_s2;
			hit_s3  <= ax_x.hit && ax_y.hit;
			ta_s3   <= ta_next;
		end
	end

	// Stage 4: sprite store access; loads write, queries read, in order
	assign ta_ok    = 32'(ta_s3) < SPRITE_TEXELS;
	assign store_we = rdy_s4 && v_s3 && (cmd_s3 == CMD_LOAD) && (32'(idx_s3) < SPRITE_TEXELS);

	ssb_ram #(
		.WIDTH (8),
		.DEPTH (SPRITE_TEXELS)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (AW'(idx_s3)),
		.wdata (val_s3),
		.re    (rdy_s4),
		.raddr (AW'(ta_s3)),
		.rdata (texel)
	);

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			cmd_s4  <= cmd_s3;
			tint_s4 <= tint_s3;
			fa_s4   <= fa_s3;
			hit_s4  <= hit_s3 && ta_ok;
		end
	end

	// Stage 5: transparency, tint and output register
	always_comb begin
		draw                   = (cmd_s4 == CMD_QUERY) && hit_s4 && (texel != 8'd0);
		rsp_next.write_enable  = draw;
		rsp_next.pixel_value   = draw ? (texel & tint_s4) : 8'd0;
		rsp_next.frame_address = (cmd_s4 == CMD_QUERY) ? fa_s4 : '0;
	end

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			rsp_s5 <= rsp_next;
		end
	end

	assign rsp_valid = v_s5;
	assign rsp       = rsp_s5;

endmodule

/* rtl/ssb_checker.sv */
// Port-level assertion checker for the sprite blitter, bound to the top level.
`include "assert_macros.svh"

module ssb_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_stall,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input ssb_pkg::out_item_t rsp
);

	// A stalled result stays offered unchanged
	`SSB_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))

	// A free output side never backs up into the input side
	`SSB_ASSERT(a_no_stall_when_drained, !rsp_stall |-> !req_stall)

	// A pixel that is not written carries no colour
	`SSB_ASSERT(a_idle_pixel_zero, rsp_valid && !rsp.write_enable |-> rsp.pixel_value == 8'd0)

	// No result comes out of a freshly reset pipe
	`SSB_ASSERT(a_empty_after_reset, $rose(arst_n) |-> !rsp_valid)

endmodule

bind scaled_sprite_blitter_core ssb_checker u_ssb_checker (.*);
